// ===== design/upe_pkg.sv =====
// ----------------------------------------------------------------------------
// upe_pkg: shared types and constants of the URL percent encoder
// Request formats, configuration bundle, queue entry and register indexes.
// ----------------------------------------------------------------------------
package upe_pkg;

  localparam int CFG_ADDR_W     = 6;
  localparam int CFG_DATA_W     = 64;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int SLOTS          = 3;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [2:0] {
    REG_MAP0 = 3'd0,
    REG_MAP1 = 3'd1,
    REG_MAP2 = 3'd2,
    REG_MAP3 = 3'd3,
    REG_PLUS = 3'd4,
    REG_KEEP = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } out_t;

  typedef struct packed {
    logic [3:0][63:0] esc_map;
    logic             plus_for_space;
    logic             keep_existing_escapes;
  } cfg_t;

  // One classified byte: either a literal to emit or a byte to escape.
  typedef struct packed {
    logic [7:0] value;
    logic       esc;
  } slot_t;

  typedef struct packed {
    slot_t [SLOTS-1:0] slots;
    logic  [1:0]       count;
    logic              fin;
  } job_t;

endpackage

// ===== design/url_percent_encoder_core.sv =====
// ----------------------------------------------------------------------------
// url_percent_encoder_core: streaming URL percent encoder
//
//   channel   signals                         direction
//   input     push, full, source              text bytes in
//   output    empty, pop, result              encoded bytes out
//   config    psel, penable, pwrite, paddr,   register access
//             pwdata, prdata, pready
//
// One result leaves per cycle while pop is high and the queue holds a job; a
// request yields zero to nine results (none while it only fills the lookahead,
// three per escaped byte, one per other byte). Requests are taken one per cycle
// while the job queue has room, so the emitter's one result per cycle sets the
// sustained rate. Results pass through the job queue and then the output
// register. Reset clears the registers, the lookahead and the queue.
// A pop held low stalls the emitter, then the queue fills and full rises.
// ----------------------------------------------------------------------------
module url_percent_encoder_core #(
  parameter int QUEUE_DEPTH = upe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  upe_pkg::in_t                   source,
  output logic                           empty,
  input  logic                           pop,
  output upe_pkg::out_t                  result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [upe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [upe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [upe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import upe_pkg::*;

  cfg_t       cfg;
  job_t       job, head;
  logic       accept, job_push, head_pop, q_empty;
  logic [1:0] pend_cnt;

  assign accept = push && !full;

  upe_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  upe_front u_front (
    .clk, .rst, .cfg, .source, .accept, .job_push, .job, .pend_cnt
  );

  upe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst,
    .wr      (job_push),
    .wr_data (job),
    .rd      (head_pop),
    .rd_data (head),
    .q_full  (full),
    .q_empty (q_empty)
  );

  upe_back u_back (
    .clk, .rst, .head,
    .head_valid (!q_empty),
    .head_pop,
    .result, .empty, .pop
  );

  // Coming out of reset nothing is pending on either side.
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full && q_empty)
    else $error("not clear after reset");

  // The end of the text is always the last result of its request.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.text_done) |-> result.run_last)
    else $error("text_done without run_last");

  // The final byte of a text flushes the lookahead.
  a_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && source.text_end) |=> pend_cnt == 2'd0)
    else $error("lookahead not flushed at end of text");

  // The lookahead never holds more than two bytes.
  a_pend_max: assert property (@(posedge clk) disable iff (rst) pend_cnt != 2'd3)
    else $error("pending count out of range");

endmodule

// ===== design/upe_regs.sv =====
// ----------------------------------------------------------------------------
// upe_regs: configuration register file
// APB-style slave holding the escape map and the two mode bits.
// ----------------------------------------------------------------------------
module upe_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [upe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [upe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [upe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output upe_pkg::cfg_t                  cfg
);
  import upe_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_MAP0: cfg.esc_map[0]            <= pwdata;
        REG_MAP1: cfg.esc_map[1]            <= pwdata;
        REG_MAP2: cfg.esc_map[2]            <= pwdata;
        REG_MAP3: cfg.esc_map[3]            <= pwdata;
        REG_PLUS: cfg.plus_for_space        <= pwdata[0];
        REG_KEEP: cfg.keep_existing_escapes <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAP0: prdata = cfg.esc_map[0];
      REG_MAP1: prdata = cfg.esc_map[1];
      REG_MAP2: prdata = cfg.esc_map[2];
      REG_MAP3: prdata = cfg.esc_map[3];
      REG_PLUS: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg.plus_for_space};
      REG_KEEP: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg.keep_existing_escapes};
      default:  prdata = '0;
    endcase
  end

endmodule

// ===== design/upe_front.sv =====
// ----------------------------------------------------------------------------
// upe_front: lookahead window and classifier
// Holds up to two pending bytes and turns each byte that is ready into a
// classified slot, pushing one job per request that yields output.
// ----------------------------------------------------------------------------
module upe_front (
  input  logic           clk,
  input  logic           rst,
  input  upe_pkg::cfg_t  cfg,
  input  upe_pkg::in_t   source,
  input  logic           accept,
  output logic           job_push,
  output upe_pkg::job_t  job,
  output logic [1:0]     pend_cnt
);
  import upe_pkg::*;

  logic [7:0] pend0, pend1;
  logic [7:0] pend0_next, pend1_next;
  logic [1:0] pend_cnt_next;
  logic [1:0] cnt_eff;
  logic [7:0] w0, w1, w2;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic slot_t classify(input cfg_t c, input logic [7:0] b,
                                     input logic ahead_ok, input logic [7:0] l1,
                                     input logic [7:0] l2);
    slot_t s;
    s.value = b;
    s.esc   = 1'b0;
    if (c.plus_for_space && b == CHAR_SPACE) begin
      s.value = CHAR_PLUS;
    end else if (c.keep_existing_escapes && b == CHAR_PCT && ahead_ok &&
                 is_hex(l1) && is_hex(l2)) begin
      s.value = CHAR_PCT;
    end else if (c.esc_map[b[7:6]][b[5:0]]) begin
      s.esc = 1'b1;
    end
    classify = s;
  endfunction

  // A count of three cannot occur; it behaves as two.
  assign cnt_eff = pend_cnt[1] ? 2'd2 : pend_cnt;

  always_comb begin
    w0 = source.text_byte;
    w1 = '0;
    w2 = '0;
    case (cnt_eff)
      2'd1: begin
        w0 = pend0;
        w1 = source.text_byte;
      end
      2'd2: begin
        w0 = pend0;
        w1 = pend1;
        w2 = source.text_byte;
      end
      default: ;
    endcase
  end

  always_comb begin
    job.slots[0] = classify(cfg, w0, cnt_eff == 2'd2, w1, w2);
    job.slots[1] = classify(cfg, w1, 1'b0, w2, w2);
    job.slots[2] = classify(cfg, w2, 1'b0, w2, w2);
    job.fin      = source.text_end;
    // Only the oldest byte is encoded unless the text ends here.
    job.count    = source.text_end ? cnt_eff + 2'd1 : 2'd1;
    job_push     = accept && (source.text_end || cnt_eff == 2'd2);
  end

  always_comb begin
    pend0_next    = pend0;
    pend1_next    = pend1;
    pend_cnt_next = pend_cnt;
    if (accept) begin
      if (source.text_end) begin
        pend_cnt_next = 2'd0;
      end else if (cnt_eff == 2'd0) begin
        pend0_next    = source.text_byte;
        pend_cnt_next = 2'd1;
      end else if (cnt_eff == 2'd1) begin
        pend1_next    = source.text_byte;
        pend_cnt_next = 2'd2;
      end else begin
        pend0_next    = pend1;
        pend1_next    = source.text_byte;
        pend_cnt_next = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 2'd0;
      pend0    <= '0;
      pend1    <= '0;
    end else begin
      pend_cnt <= pend_cnt_next;
      pend0    <= pend0_next;
      pend1    <= pend1_next;
    end
  end

endmodule

// ===== design/upe_queue.sv =====
// ----------------------------------------------------------------------------
// upe_queue: job queue between classifier and emitter
// Small first-in first-out store; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module upe_queue #(
  parameter int DEPTH = upe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  upe_pkg::job_t wr_data,
  input  logic          rd,
  output upe_pkg::job_t rd_data,
  output logic          q_full,
  output logic          q_empty
);
  import upe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] cnt;
  logic             do_wr, do_rd;

  assign q_full  = (cnt == CNT_W'(DEPTH));
  assign q_empty = (cnt == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== design/upe_back.sv =====
// ----------------------------------------------------------------------------
// upe_back: output emitter
// Walks the slots of the head job, expanding escaped bytes into three
// characters, one result per cycle into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
module upe_back (
  input  logic          clk,
  input  logic          rst,
  input  upe_pkg::job_t head,
  input  logic          head_valid,
  output logic          head_pop,
  output upe_pkg::out_t result,
  output logic          empty,
  input  logic          pop
);
  import upe_pkg::*;

  localparam logic [15:0][7:0] HEX_CHARS = {
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  logic [1:0] slot_idx, slot_idx_next;
  logic [1:0] digit, digit_next;
  logic       out_valid, out_valid_next;
  out_t       out_reg, out_reg_next;
  slot_t      cur;
  logic       slot_last, job_last, advance;

  assign cur       = head.slots[slot_idx];
  assign slot_last = !cur.esc || digit == 2'd2;
  assign job_last  = slot_last && (slot_idx == head.count - 2'd1);
  assign advance   = head_valid && (!out_valid || pop);
  assign head_pop  = advance && job_last;
  assign empty     = !out_valid;
  assign result    = out_reg;

  always_comb begin
    out_reg_next   = out_reg;
    out_valid_next = out_valid && !pop;
    slot_idx_next  = slot_idx;
    digit_next     = digit;
    if (advance) begin
      out_valid_next = 1'b1;
      if (!cur.esc) begin
        out_reg_next.out_byte = cur.value;
      end else begin
        case (digit)
          2'd0:    out_reg_next.out_byte = CHAR_PCT;
          2'd1:    out_reg_next.out_byte = HEX_CHARS[cur.value[7:4]];
          default: out_reg_next.out_byte = HEX_CHARS[cur.value[3:0]];
        endcase
      end
      out_reg_next.run_last  = job_last;
      out_reg_next.text_done = job_last && head.fin;
      if (job_last) begin
        slot_idx_next = 2'd0;
        digit_next    = 2'd0;
      end else if (slot_last) begin
        slot_idx_next = slot_idx + 2'd1;
        digit_next    = 2'd0;
      end else begin
        digit_next = digit + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_reg <= out_reg_next;
    if (rst) begin
      out_valid <= 1'b0;
      slot_idx  <= 2'd0;
      digit     <= 2'd0;
    end else begin
      out_valid <= out_valid_next;
      slot_idx  <= slot_idx_next;
      digit     <= digit_next;
    end
  end

endmodule
